// ===== rtl/core/kpdc_pkg.sv =====
`default_nettype none

package kpdc_pkg;

    // Sizing of the key set and of the millisecond clock.
    localparam int NUM_KEYS  = 7;
    localparam int TIME_BITS = 32;

    // Index width of one key and the fixed widths of the fields.
    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int REPORT_W  = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_NUM_W = 3;
    localparam int HELD_W    = 32;
    localparam int POS_W     = 4;

    // Hold check: (repeat count + 1) * repeat interval.
    localparam int PROD_W = 2 * CFG_W + 1;
    localparam int CMP_W  = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd900;
    localparam logic [CFG_W-1:0] HOLD_LIMIT_RST  = 16'd900;
    localparam logic [CFG_W-1:0] REPEAT_RST      = 16'd1000;
    localparam logic [CFG_W-1:0] SCAN_PERIOD_RST = 16'd100;

    // Input opcodes.
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result kinds.
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_HOLD  = 1'b1;

    typedef enum logic [1:0] {
        CMD_PRESS,
        CMD_RELEASE,
        CMD_SCAN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [KEY_IDX_W-1:0]  key;
        logic [TIME_BITS-1:0]  stamp;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_limit;
        logic [CFG_W-1:0] hold_limit;
        logic [CFG_W-1:0] repeat_ms;
        logic [CFG_W-1:0] scan_period;
    } cfg_t;

    typedef struct packed {
        logic                 kind;
        logic [KEY_NUM_W-1:0] key_num;
        logic [HELD_W-1:0]    held;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_FLUSH
    } back_state_t;

    // Position of the lowest set bit of a report.
    function automatic logic [POS_W-1:0] lowest_bit(input logic [REPORT_W-1:0] ks);
        logic [POS_W-1:0] pos;
        pos = POS_W'(REPORT_W);
        for (int i = REPORT_W - 1; i >= 0; i--) begin
            if (ks[i]) begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kpdc_if.sv =====
`default_nettype none

// Channel of key-state reports and millisecond ticks.
interface kpdc_in_if
    import kpdc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [REPORT_W-1:0] key_bits;

    modport source (output valid, output opcode, output key_bits, input ready);
    modport sink (input valid, input opcode, input key_bits, output ready);
endinterface

// Channel of press results.
interface kpdc_out_if
    import kpdc_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 event_kind;
    logic [KEY_NUM_W-1:0] key_index;
    logic [HELD_W-1:0]    held_ms;
    logic                 last;

    modport source (output valid, output event_kind, output key_index, output held_ms,
                    output last, input ready);
    modport sink (input valid, input event_kind, input key_index, input held_ms,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kpdc_cmd_queue.sv =====
`default_nettype none

module kpdc_cmd_queue
    import kpdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Storage of the queued commands.
    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kpdc_front.sv =====
`default_nettype none

module kpdc_front
    import kpdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    kpdc_in_if.sink          report,
    input  wire cfg_t        cfg,
    input  wire logic        q_full,
    output logic             q_push,
    output cmd_t             q_cmd
);

    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_next;
    logic [CFG_W-1:0]     scan_cnt_reg;
    logic [CFG_W-1:0]     scan_cnt_next;
    logic [REPORT_W-1:0]  prev_reg;
    logic [REPORT_W-1:0]  prev_next;
    logic [CFG_W-1:0]     period;
    logic [CFG_W-1:0]     scan_inc;
    logic [POS_W-1:0]     pos;
    logic                 accept;
    logic                 onehot;

    assign report.ready = !q_full;
    assign accept       = report.valid && !q_full;

    assign period   = (cfg.scan_period == '0) ? CFG_W'(1) : cfg.scan_period;
    assign scan_inc = scan_cnt_reg + CFG_W'(1);
    assign pos      = lowest_bit(report.key_bits);
    assign onehot   = (report.key_bits != '0)
                   && ((report.key_bits & (report.key_bits - REPORT_W'(1))) == '0);

    // Classify an accepted item into a command for the back part.
    always_comb begin
        now_next      = now_reg;
        scan_cnt_next = scan_cnt_reg;
        prev_next     = prev_reg;
        q_push        = 1'b0;
        q_cmd.kind    = CMD_PRESS;
        q_cmd.key     = KEY_IDX_W'(pos);
        q_cmd.stamp   = now_reg;
        if (accept) begin
            if (report.opcode == OP_TICK) begin
                now_next = now_reg + TIME_BITS'(1);
                if (scan_inc >= period) begin
                    scan_cnt_next = '0;
                    q_push        = 1'b1;
                    q_cmd.kind    = CMD_SCAN;
                    q_cmd.stamp   = now_next;
                end
                else begin
                    scan_cnt_next = scan_inc;
                end
            end
            else if (report.key_bits != prev_reg) begin
                prev_next = report.key_bits;
                if (report.key_bits == '0) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_RELEASE;
                end
                else if (onehot && (pos < POS_W'(NUM_KEYS))) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_PRESS;
                end
            end
        end
    end

    // Millisecond clock, scan divider and last report.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            now_reg      <= '0;
            scan_cnt_reg <= '0;
            prev_reg     <= '0;
        end
        else begin
            now_reg      <= now_next;
            scan_cnt_reg <= scan_cnt_next;
            prev_reg     <= prev_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kpdc_back.sv =====
`default_nettype none

module kpdc_back
    import kpdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    kpdc_out_if.source       result
);

    back_state_t          state_reg;
    back_state_t          state_next;
    cmd_t                 cmd_reg;
    logic [KEY_IDX_W-1:0] k_reg;
    logic [NUM_KEYS-1:0]  down_valid_reg;
    logic [TIME_BITS-1:0] down_time_reg [NUM_KEYS];
    logic [CFG_W-1:0]     rep_cnt_reg [NUM_KEYS];
    logic                 pend_valid_reg;
    result_t              pend_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    logic                 out_last_reg;

    logic [TIME_BITS-1:0] diff;
    logic [CFG_W-1:0]     rc;
    logic [CFG_W-1:0]     per;
    logic [CFG_W:0]       rc_inc;
    logic [PROD_W-1:0]    prod;
    logic                 rel_hit;
    logic                 scan_hit;
    logic                 hit;
    logic                 out_free;
    logic                 step;
    logic                 last_key;
    logic                 flush_push;
    logic                 flush_done;
    logic                 take;
    logic                 take_press;
    logic                 take_sweep;
    logic                 push_out;
    logic                 push_last;
    logic [KEY_IDX_W:0]   key_num;
    result_t              found;

    // Evaluation of the key under the sweep index.
    assign diff   = cmd_reg.stamp - down_time_reg[k_reg];
    assign rc     = rep_cnt_reg[k_reg];
    assign per    = (cfg.repeat_ms == '0) ? CFG_W'(1) : cfg.repeat_ms;
    assign rc_inc = {1'b0, rc} + (CFG_W + 1)'(1);
    assign prod   = PROD_W'(rc_inc) * PROD_W'(per);

    assign rel_hit  = down_valid_reg[k_reg] && (diff != '0)
                   && (diff < TIME_BITS'(cfg.short_limit));
    assign scan_hit = down_valid_reg[k_reg] && (diff > TIME_BITS'(cfg.hold_limit))
                   && (CMP_W'(prod) <= CMP_W'(diff)) && (rc != '1);
    assign hit      = (state_reg == BK_SWEEP)
                   && ((cmd_reg.kind == CMD_RELEASE) ? rel_hit : scan_hit);

    assign key_num       = {1'b0, k_reg} + (KEY_IDX_W + 1)'(1);
    assign found.kind    = (cmd_reg.kind == CMD_RELEASE) ? KIND_SHORT : KIND_HOLD;
    assign found.key_num = KEY_NUM_W'(key_num);
    assign found.held    = HELD_W'(diff);

    assign out_free = !out_valid_reg || result.ready;
    assign last_key = (k_reg == KEY_IDX_W'(NUM_KEYS - 1));

    // Control of the sweep, the flush and the command intake.
    always_comb begin
        step       = 1'b0;
        flush_push = 1'b0;
        flush_done = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
            end
            BK_SWEEP: begin
                step = !(hit && pend_valid_reg && !out_free);
            end
            BK_FLUSH: begin
                flush_push = pend_valid_reg && out_free;
                flush_done = !pend_valid_reg || out_free;
            end
            default: begin
            end
        endcase
        take       = q_valid && ((state_reg == BK_IDLE) || flush_done);
        take_press = take && (q_cmd.kind == CMD_PRESS);
        take_sweep = take && (q_cmd.kind != CMD_PRESS);
        q_pop      = take;
        push_out   = (step && hit && pend_valid_reg) || flush_push;
        push_last  = flush_push;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (take_sweep) begin
                    state_next = BK_SWEEP;
                end
            end
            BK_SWEEP: begin
                if (step && last_key) begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                if (flush_done) begin
                    state_next = take_sweep ? BK_SWEEP : BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State, sweep index and handshake registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= BK_IDLE;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (take_sweep) begin
                k_reg <= '0;
            end
            else if (step) begin
                k_reg <= k_reg + KEY_IDX_W'(1);
            end
            if (step && hit) begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_push) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out) begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-key flags and repeat counts.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            down_valid_reg <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                rep_cnt_reg[i] <= '0;
            end
        end
        else begin
            if (take_press && !down_valid_reg[q_cmd.key]) begin
                down_valid_reg[q_cmd.key] <= 1'b1;
            end
            if (step && (cmd_reg.kind == CMD_RELEASE) && down_valid_reg[k_reg]) begin
                down_valid_reg[k_reg] <= 1'b0;
                rep_cnt_reg[k_reg]    <= '0;
            end
            else if (step && hit) begin
                rep_cnt_reg[k_reg] <= rc + CFG_W'(1);
            end
        end
    end

    // Press times, current command and result payloads.
    always_ff @(posedge clk) begin
        if (take_press && !down_valid_reg[q_cmd.key]) begin
            down_time_reg[q_cmd.key] <= q_cmd.stamp;
        end
        if (take_sweep) begin
            cmd_reg <= q_cmd;
        end
        if (step && hit) begin
            pend_reg <= found;
        end
        if (push_out) begin
            out_reg      <= pend_reg;
            out_last_reg <= push_last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.event_kind = out_reg.kind;
    assign result.key_index  = out_reg.key_num;
    assign result.held_ms    = out_reg.held;
    assign result.last       = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/key_press_duration_classifier_core.sv =====
`default_nettype none

// Key press duration classifier.
// The report channel carries key-state reports (opcode 0) and millisecond
// ticks (opcode 1); a transfer takes place when valid and ready are both high.
// The result channel carries short-press and hold-repeat results, lowest key
// first, with last set on the final result caused by one report or tick.
// The front part takes one transfer per cycle while its four-entry command
// queue has room, and turns presses, releases and hold scans into commands.
// A press command is taken from the queue and marks its key down unless it
// is down already. A release or a hold scan leaves the queue and sweeps the
// seven keys one per cycle while no result is held up; its flush overlaps
// the intake of the next command, so a new sweep starts as the last one
// flushes. Each result passes through a pending register and then the
// output register before it becomes valid.
// A result waits in the output register while the receiver stalls; the sweep
// halts only when a second result is ready and the output is still full, and
// the front keeps accepting until the queue fills.
// The configuration port writes one register per cycle with cfg_we high.
// Reset clears the clock, the scan divider, the last report, all keys and
// the queue, and restores the register defaults (900, 900, 1000, 100).
module key_press_duration_classifier_core
    import kpdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    kpdc_in_if.sink                   report,
    kpdc_out_if.source                result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.short_limit <= SHORT_LIMIT_RST;
            cfg_reg.hold_limit  <= HOLD_LIMIT_RST;
            cfg_reg.repeat_ms   <= REPEAT_RST;
            cfg_reg.scan_period <= SCAN_PERIOD_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_SHORT_LIMIT: cfg_reg.short_limit <= cfg_wdata;
                REG_HOLD_LIMIT:  cfg_reg.hold_limit  <= cfg_wdata;
                REG_REPEAT:      cfg_reg.repeat_ms   <= cfg_wdata;
                REG_SCAN_PERIOD: cfg_reg.scan_period <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front part: clock, divider and classification of items.
    kpdc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    // Command queue between the two parts.
    kpdc_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back part: key table and result sweeps.
    kpdc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_head_valid),
        .q_cmd   (q_head_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== tb/press_event_checker.sv =====
`default_nettype none

// Watches the report and result channels and the configuration port, keeps its
// own copy of the classifier state, and checks every result transfer against
// the oldest predicted event.
module press_event_checker
    import kpdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    kpdc_in_if                        report,
    kpdc_out_if                       result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output int                        mismatch_count,
    output int                        events_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic                 kind;
        logic [KEY_NUM_W-1:0] key_num;
        logic [HELD_W-1:0]    held;
        logic                 last;
    } press_event_t;

    // Mirror of the registers and of the key tracking state.
    cfg_t                 limits;
    logic [TIME_BITS-1:0] clock_ms;
    logic [CFG_W-1:0]     scan_ticks;
    logic [REPORT_W-1:0]  last_report;
    logic                 key_down     [NUM_KEYS];
    logic [TIME_BITS-1:0] press_ms     [NUM_KEYS];
    logic [CFG_W-1:0]     repeats_done [NUM_KEYS];
    press_event_t         events_q     [$];

    initial begin
        mismatch_count = 0;
        events_due     = 0;
    end

    task automatic log_mismatch(input string what, input press_event_t want,
                                input press_event_t got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("%0t ns: %s: expected kind %0d key %0d held %0d last %0d",
                     $time, what, want.kind, want.key_num, want.held, want.last);
            $display("    got kind %0d key %0d held %0d last %0d",
                     got.kind, got.key_num, got.held, got.last);
        end
    endtask

    // Compare one result transfer with the oldest expected event.
    task automatic check_event(input press_event_t got);
        press_event_t want;
        if (events_q.size() == 0) begin
            log_mismatch("result with no event expected", '0, got);
        end
        else begin
            want = events_q[0];
            events_q.delete(0);
            if (got.kind !== want.kind || got.key_num !== want.key_num ||
                got.held !== want.held || got.last !== want.last) begin
                log_mismatch("result differs", want, got);
            end
        end
    endtask

    // Work out the events caused by one accepted report or tick.
    task automatic classify_input(input logic op, input logic [REPORT_W-1:0] ks);
        press_event_t         batch [$];
        press_event_t         ev;
        logic [CFG_W-1:0]     period;
        logic [CFG_W-1:0]     step;
        logic [TIME_BITS-1:0] held;
        if (op == OP_TICK) begin
            period   = (limits.scan_period == '0) ? CFG_W'(1) : limits.scan_period;
            step     = (limits.repeat_ms == '0) ? CFG_W'(1) : limits.repeat_ms;
            clock_ms = clock_ms + 1'b1;
            scan_ticks = scan_ticks + 1'b1;
            if (scan_ticks >= period) begin
                scan_ticks = '0;
                // One hold repeat per key per scan, while the count lags the held time.
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (key_down[k]) begin
                        held = clock_ms - press_ms[k];
                        if (held > TIME_BITS'(limits.hold_limit) &&
                            repeats_done[k] != '1 &&
                            TIME_BITS'(repeats_done[k]) < held / TIME_BITS'(step)) begin
                            repeats_done[k] = repeats_done[k] + 1'b1;
                            ev    = '{KIND_HOLD, KEY_NUM_W'(k + 1), HELD_W'(held), 1'b0};
                            batch = {batch, ev};
                        end
                    end
                end
            end
        end
        else if (ks != last_report) begin
            last_report = ks;
            if (ks == '0) begin
                // Release everything; only quick, nonzero presses are reported.
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (key_down[k]) begin
                        held = clock_ms - press_ms[k];
                        if (held != '0 && held < TIME_BITS'(limits.short_limit)) begin
                            ev    = '{KIND_SHORT, KEY_NUM_W'(k + 1), HELD_W'(held), 1'b0};
                            batch = {batch, ev};
                        end
                        key_down[k]     = 1'b0;
                        repeats_done[k] = '0;
                    end
                end
            end
            else if ((ks & (ks - 8'd1)) == 8'd0) begin
                // A single key; a key that is already down keeps its press time.
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (ks[k] && !key_down[k]) begin
                        key_down[k] = 1'b1;
                        press_ms[k] = clock_ms;
                    end
                end
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        events_q = {events_q, batch};
    endtask

    // Results are checked before the same edge's report is predicted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limits      = '{SHORT_LIMIT_RST, HOLD_LIMIT_RST, REPEAT_RST, SCAN_PERIOD_RST};
            clock_ms    = '0;
            scan_ticks  = '0;
            last_report = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_down[k]     = 1'b0;
                press_ms[k]     = '0;
                repeats_done[k] = '0;
            end
            events_q.delete();
            events_due <= 0;
        end
        else begin
            if (result.valid && result.ready) begin
                check_event('{result.event_kind, result.key_index, result.held_ms,
                              result.last});
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_SHORT_LIMIT: limits.short_limit = cfg_wdata;
                    REG_HOLD_LIMIT:  limits.hold_limit  = cfg_wdata;
                    REG_REPEAT:      limits.repeat_ms   = cfg_wdata;
                    REG_SCAN_PERIOD: limits.scan_period = cfg_wdata;
                    default:         ;
                endcase
            end
            if (report.valid && report.ready) begin
                classify_input(report.opcode, report.key_bits);
            end
            events_due <= events_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/key_press_duration_classifier_core_tb.sv =====
`default_nettype none

module key_press_duration_classifier_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kpdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 36;
    localparam int NUM_PHASES     = 8;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   mismatch_count;
    int                   events_due;
    int                   items_sent;
    int                   idle_cycles;
    bit                   src_steady;
    bit                   sink_steady;
    logic [REPORT_W-1:0]  sent_report;

    kpdc_in_if  report_ch ();
    kpdc_out_if result_ch ();

    key_press_duration_classifier_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .report    (report_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    press_event_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .report         (report_ch),
        .result         (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .events_due     (events_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver stalls.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!sink_steady && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (report_ch.valid && report_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // One report transfer; valid stays high between back-to-back items.
    task automatic send(input logic op, input logic [REPORT_W-1:0] ks);
        int gap;
        gap = 0;
        if (!src_steady && $urandom_range(0, 1) == 0)
        begin
            gap = gap_len();
        end
        if (gap > 0)
        begin
            report_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        report_ch.valid    <= 1'b1;
        report_ch.opcode   <= op;
        report_ch.key_bits <= ks;
        if (op == OP_REPORT)
        begin
            sent_report = ks;
        end
        items_sent++;
        do @(posedge clk); while (!report_ch.ready);
    endtask

    // Ticks carry random key bits, which the block ignores.
    task automatic tick_burst(input int count);
        repeat (count) send(OP_TICK, REPORT_W'($urandom));
    endtask

    task automatic hold_until_drained();
        report_ch.valid <= 1'b0;
        do @(posedge clk); while (events_due != 0);
    endtask

    // Drain, then let the back end finish any sweep that produced nothing.
    task automatic drain_and_settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        write_reg(REG_SHORT_LIMIT, c.short_limit);
        write_reg(REG_HOLD_LIMIT, c.hold_limit);
        write_reg(REG_REPEAT, c.repeat_ms);
        write_reg(REG_SCAN_PERIOD, c.scan_period);
        cfg_we <= 1'b0;
    endtask

    // Press one to three keys, hold for a while, then usually release.
    task automatic key_sequence(input int max_burst);
        int presses;
        int burst;
        presses = $urandom_range(1, 3);
        for (int i = 0; i < presses; i++)
        begin
            send(OP_REPORT, REPORT_W'(1) << $urandom_range(0, NUM_KEYS - 1));
            tick_burst($urandom_range(0, 2));
        end
        burst = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4)
                                            : $urandom_range(0, max_burst);
        tick_burst(burst);
        if ($urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send(OP_REPORT, REPORT_W'($urandom));
            end
            send(OP_REPORT, '0);
        end
    endtask

    task automatic run_phase(input cfg_t c, input int count);
        int stop_at;
        int max_burst;
        int r;
        drain_and_settle();
        set_config(c);
        max_burst = int'(c.hold_limit) + 3 * int'(c.repeat_ms) + 8;
        if (max_burst > 60)
        begin
            max_burst = 60;
        end
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                key_sequence(max_burst);
            else if (r < 84)
                send(OP_REPORT, REPORT_W'($urandom));
            else if (r < 90)
                send(OP_REPORT, sent_report);
            else if (r < 97)
                tick_burst($urandom_range(1, 8));
            else
                hold_until_drained();
        end
    endtask

    initial
    begin
        cfg_t plan [NUM_PHASES];

        rst_n              = 1'b0;
        report_ch.valid    = 1'b0;
        report_ch.opcode   = OP_REPORT;
        report_ch.key_bits = '0;
        result_ch.ready    = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_SHORT_LIMIT;
        cfg_wdata          = '0;
        items_sent         = 0;
        idle_cycles        = 0;
        src_steady         = 1'b0;
        sink_steady        = 1'b0;
        sent_report        = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset defaults: unchanged, multi-key and nonexistent-key reports,
        // a repeated press, short presses and a zero-length press.
        send(OP_REPORT, 8'h00);
        send(OP_REPORT, 8'h01);
        send(OP_REPORT, 8'h01);
        tick_burst(3);
        send(OP_REPORT, 8'h02);
        send(OP_REPORT, 8'h01);
        send(OP_REPORT, 8'h03);
        send(OP_REPORT, 8'h80);
        send(OP_REPORT, 8'h40);
        tick_burst(2);
        send(OP_REPORT, 8'h00);
        send(OP_REPORT, 8'h04);
        send(OP_REPORT, 8'h00);
        send(OP_REPORT, 8'hFF);
        send(OP_REPORT, 8'h00);

        // Lowest settings: a hold scan on every tick, release too long.
        drain_and_settle();
        set_config('{16'd1, 16'd1, 16'd1, 16'd1});
        send(OP_REPORT, 8'h10);
        tick_burst(3);
        send(OP_REPORT, 8'h00);

        plan[0] = '{16'd20, 16'd5, 16'd3, 16'd2};
        plan[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        plan[2] = '{16'd8, 16'd1, 16'd0, 16'd0};
        plan[3] = '{16'd12, 16'd10, 16'd4, 16'd3};
        plan[4] = '{CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 20)),
                    CFG_W'($urandom_range(1, 10)), CFG_W'($urandom_range(1, 5))};
        plan[5] = '{16'd3, 16'd2, 16'd1, 16'd1};
        plan[6] = '{CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(1, 8)),
                    CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 4))};
        plan[7] = '{SHORT_LIMIT_RST, HOLD_LIMIT_RST, REPEAT_RST, SCAN_PERIOD_RST};

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            src_steady  = (p == 3 || p == 6);
            sink_steady = (p == 4 || p == 6);
            run_phase(plan[p], PHASE_ITEMS);
        end

        drain_and_settle();
        if (mismatch_count == 0 && events_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
